@@ rtl/core/orvm_pkg.sv @@
// ----------------------------------------------------------------------------
// Ramped velocity mixer package
// Shared widths, wheel coefficients and the lane status record.
// ----------------------------------------------------------------------------
package orvm_pkg;

  // Field widths.
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned STEP_W  = 15;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned DIFF_W  = 17;

  // Step counts carry 8 fraction bits.
  localparam int unsigned STEP_FRAC = 8;
  // Dividend width: |diff| (16 bits) shifted by the fraction bits.
  localparam int unsigned NUM_W = 24;
  // Quotient width of the ramp divider.
  localparam int unsigned QUO_W = 24;

  // Wheel coefficients, unsigned Q.16.
  localparam int unsigned COEF_FRAC = 16;
  localparam logic [20:0] K_LIN  = 21'd1040254;
  localparam logic [20:0] K_HALF = 21'd520127;
  localparam logic [20:0] K_SQRT = 21'd900886;
  localparam logic [20:0] K_TURN = 21'd189950;

  // Configuration register indexes.
  localparam logic [1:0] REG_STEP_FWD  = 2'd0;
  localparam logic [1:0] REG_STEP_SIDE = 2'd1;
  localparam logic [1:0] REG_STEP_TURN = 2'd2;

  // Handshake between sequencer and divider lanes.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

@@ rtl/core/orvm_div_lane.sv @@
// ----------------------------------------------------------------------------
// Ramp divider lane
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module orvm_div_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [orvm_pkg::NUM_W-1:0]        num,
  input  logic [orvm_pkg::QUO_W-1:0]        den,
  output logic                              busy,
  output logic [orvm_pkg::QUO_W-1:0]        quo
);

  localparam int unsigned CNT_W = $clog2(orvm_pkg::NUM_W + 1);

  logic [orvm_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [orvm_pkg::QUO_W:0]   rem_r, rem_nxt;
  logic [orvm_pkg::QUO_W-1:0] den_r, quo_r, quo_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [orvm_pkg::QUO_W:0]   trial;

  // One shift and trial subtract per cycle.
  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    trial   = '0;
    if (start) begin
      num_nxt = num;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = CNT_W'(orvm_pkg::NUM_W);
    end else if (cnt_r != '0) begin
      trial   = {rem_r[orvm_pkg::QUO_W-1:0], num_r[orvm_pkg::NUM_W-1]};
      num_nxt = {num_r[orvm_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[orvm_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[orvm_pkg::QUO_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;

endmodule

@@ rtl/core/orvm_kin.sv @@
// ----------------------------------------------------------------------------
// Wheel kinematics merge
// Multiplies the ramped speeds by the wheel coefficients over three stages
// and rounds and saturates the three wheel sums.
// ----------------------------------------------------------------------------
module orvm_kin (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [orvm_pkg::SPEED_W-1:0] vx,
  input  logic signed [orvm_pkg::SPEED_W-1:0] vy,
  input  logic signed [orvm_pkg::SPEED_W-1:0] va,
  output logic                                done,
  output logic signed [orvm_pkg::RATE_W-1:0]  rate_a,
  output logic signed [orvm_pkg::RATE_W-1:0]  rate_b,
  output logic signed [orvm_pkg::RATE_W-1:0]  rate_c
);

  localparam int unsigned PROD_W = 38;
  localparam int unsigned ACC_W  = 40;

  logic [2:0] vld_r;
  logic signed [PROD_W-1:0] p_lin_r, p_half_r, p_sqrt_r, p_turn_r;
  logic signed [ACC_W-1:0]  acc_a_r, acc_b_r, acc_c_r;
  logic signed [orvm_pkg::RATE_W-1:0] ra_r, rb_r, rc_r;

  // Round to nearest, ties away from zero, then saturate.
  function automatic logic signed [orvm_pkg::RATE_W-1:0] rnd_sat(
    input logic signed [ACC_W-1:0] acc);
    logic [ACC_W-1:0] mag;
    logic signed [ACC_W-1:0] r;
    begin
      mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      mag = (mag + (ACC_W'(1) << (orvm_pkg::COEF_FRAC - 1))) >> orvm_pkg::COEF_FRAC;
      r   = acc[ACC_W-1] ? -$signed(mag) : $signed(mag);
      if (r > ACC_W'(signed'(24'sh7FFFFF))) begin
        rnd_sat = 24'sh7FFFFF;
      end else if (r < $signed({{(ACC_W-24){1'b1}}, 24'h800000})) begin
        rnd_sat = 24'sh800000;
      end else begin
        rnd_sat = r[orvm_pkg::RATE_W-1:0];
      end
    end
  endfunction

  // Stage valid chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  // Stage 1 products, stage 2 sums, stage 3 round and saturate.
  always_ff @(posedge clk) begin
    p_lin_r  <= PROD_W'(vy * $signed({1'b0, orvm_pkg::K_LIN}));
    p_half_r <= PROD_W'(vy * $signed({1'b0, orvm_pkg::K_HALF}));
    p_sqrt_r <= PROD_W'(vx * $signed({1'b0, orvm_pkg::K_SQRT}));
    p_turn_r <= PROD_W'(va * $signed({1'b0, orvm_pkg::K_TURN}));
    acc_a_r  <= ACC_W'(p_lin_r) + ACC_W'(p_turn_r);
    acc_b_r  <= ACC_W'(p_turn_r) - ACC_W'(p_half_r) - ACC_W'(p_sqrt_r);
    acc_c_r  <= ACC_W'(p_turn_r) - ACC_W'(p_half_r) + ACC_W'(p_sqrt_r);
    ra_r     <= rnd_sat(acc_a_r);
    rb_r     <= rnd_sat(acc_b_r);
    rc_r     <= rnd_sat(acc_c_r);
  end

  assign done   = vld_r[2];
  assign rate_a = ra_r;
  assign rate_b = rb_r;
  assign rate_c = rc_r;

endmodule

@@ rtl/core/omniwheel_ramped_velocity_mixer.sv @@
// ----------------------------------------------------------------------------
// Omni-wheel ramped velocity mixer
// Slew-limits three body speeds together and maps them to three wheel rates.
// ----------------------------------------------------------------------------
// Usage: one input word per control tick carries the target forward, side
// and turn speeds (signed Q4.12). The block moves its held speeds toward the
// targets so all axes arrive in the same number of ticks, then produces one
// output word with three saturated wheel rates (Q12.12) and the held speeds.
// One item is worked at a time. After acceptance, three parallel step-count
// dividers run, then three parallel increment dividers (one quotient bit per
// cycle), then sequencing and three kinematics stages lead to out_tvalid.
// in_tready is high only while no item is in flight and the output register
// is empty, so a new item is taken only after the last one has left.
// If the receiver stalls, the result holds in the output register and no
// new word is taken until it leaves. Reset (synchronous, active low) clears
// the held speeds and loads the default step limits. Step registers are to
// be written through cfg_* only while idle; the block itself does not
// enforce this. An index beyond the list is ignored.
// ----------------------------------------------------------------------------
module omniwheel_ramped_velocity_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // target_forward [15:0], target_side [31:16], target_turn [47:32]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // wheel_a_rate [23:0], wheel_b_rate [47:24], wheel_c_rate [71:48],
  // ramped_forward [87:72], ramped_side [103:88], ramped_turn [119:104]
  output logic [119:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);

  localparam int unsigned NL = 3;
  localparam int unsigned SW = orvm_pkg::SPEED_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_MAX, ST_INC, ST_KIN, ST_OUT
  } state_t;

  state_t state_r;
  logic [orvm_pkg::STEP_W-1:0] max_step_r [NL];
  logic signed [SW-1:0] now_r [NL];
  logic signed [SW-1:0] tgt_r [NL];
  logic signed [orvm_pkg::DIFF_W-1:0] diff [NL];
  logic [SW-1:0] mag [NL];
  logic [orvm_pkg::QUO_W-1:0] den [NL];
  logic [orvm_pkg::QUO_W-1:0] quo [NL];
  logic [orvm_pkg::QUO_W-1:0] steps_r;
  orvm_pkg::div_ctl_t ctl [NL];
  logic div_start_r, kin_start_r, inc_phase_r;
  logic kin_done;
  logic signed [orvm_pkg::RATE_W-1:0] ra, rb, rc;
  logic [119:0] out_r;
  logic out_vld_r;

  // Per-lane difference, magnitude and divisor selection.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      diff[i] = orvm_pkg::DIFF_W'(tgt_r[i]) - orvm_pkg::DIFF_W'(now_r[i]);
      mag[i]  = diff[i][orvm_pkg::DIFF_W-1] ? SW'(-diff[i]) : SW'(diff[i]);
      if (inc_phase_r) begin
        den[i] = steps_r;
      end else begin
        den[i] = (max_step_r[i] == '0) ? orvm_pkg::QUO_W'(1)
                                       : orvm_pkg::QUO_W'(max_step_r[i]);
      end
    end
  end

  // Divider lanes.
  for (genvar g = 0; g < NL; g++) begin : g_lane
    assign ctl[g].start = div_start_r;
    orvm_div_lane u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (ctl[g].start),
      .num   ({mag[g], orvm_pkg::STEP_FRAC'(0)}),
      .den   (den[g]),
      .busy  (ctl[g].busy),
      .quo   (quo[g])
    );
  end

  orvm_kin u_kin (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (kin_start_r),
    .vx     (now_r[0]),
    .vy     (now_r[1]),
    .va     (now_r[2]),
    .done   (kin_done),
    .rate_a (ra),
    .rate_b (rb),
    .rate_c (rc)
  );

  assign in_tready = (state_r == ST_IDLE) && !out_vld_r;

  // Sequencer, held speeds, configuration and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      div_start_r   <= 1'b0;
      kin_start_r   <= 1'b0;
      inc_phase_r   <= 1'b0;
      out_vld_r     <= 1'b0;
      max_step_r[0] <= 15'd1311;
      max_step_r[1] <= 15'd786;
      max_step_r[2] <= 15'd2621;
      for (int i = 0; i < NL; i++) begin
        now_r[i] <= '0;
      end
    end else begin
      div_start_r <= 1'b0;
      kin_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          orvm_pkg::REG_STEP_FWD:  max_step_r[0] <= cfg_wdata;
          orvm_pkg::REG_STEP_SIDE: max_step_r[1] <= cfg_wdata;
          orvm_pkg::REG_STEP_TURN: max_step_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            tgt_r[0]    <= in_tdata[15:0];
            tgt_r[1]    <= in_tdata[31:16];
            tgt_r[2]    <= in_tdata[47:32];
            inc_phase_r <= 1'b0;
            div_start_r <= 1'b1;
            state_r     <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!div_start_r && !ctl[0].busy) begin
            state_r <= ST_MAX;
          end
        end
        ST_MAX: begin
          // Largest step count, at least one whole step.
          if (quo[0] <= (orvm_pkg::QUO_W'(1) << orvm_pkg::STEP_FRAC) &&
              quo[1] <= (orvm_pkg::QUO_W'(1) << orvm_pkg::STEP_FRAC) &&
              quo[2] <= (orvm_pkg::QUO_W'(1) << orvm_pkg::STEP_FRAC)) begin
            steps_r <= orvm_pkg::QUO_W'(1) << orvm_pkg::STEP_FRAC;
          end else begin
            steps_r <= (quo[0] >= quo[1] && quo[0] >= quo[2]) ? quo[0] :
                       (quo[1] >= quo[2]) ? quo[1] : quo[2];
          end
          inc_phase_r <= 1'b1;
          div_start_r <= 1'b1;
          state_r     <= ST_INC;
        end
        ST_INC: begin
          if (!div_start_r && !ctl[0].busy) begin
            for (int i = 0; i < NL; i++) begin
              now_r[i] <= diff[i][orvm_pkg::DIFF_W-1] ? now_r[i] - SW'(quo[i])
                                                      : now_r[i] + SW'(quo[i]);
            end
            kin_start_r <= 1'b1;
            state_r     <= ST_KIN;
          end
        end
        ST_KIN: begin
          if (kin_done) begin
            out_r     <= {now_r[2], now_r[1], now_r[0], rc, rb, ra};
            out_vld_r <= 1'b1;
            state_r   <= ST_OUT;
          end
        end
        ST_OUT: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

endmodule

@@ rtl/core/orvm_checker.sv @@
// ----------------------------------------------------------------------------
// Mixer port checker
// Watches the top-level ports for handshake and sequencing faults.
// ----------------------------------------------------------------------------
module orvm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);

  // A held result keeps its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // No new word is taken while a result waits.
  a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  // An accepted word does not finish in the next cycle.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !out_tvalid && !in_tready)
    else $error("item finished too early");

  // Output is idle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind omniwheel_ramped_velocity_mixer orvm_checker u_orvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
